/* hdl/roi_point_pool_3d_top_defines.svh */
// ----------------------------------------------------------------------------
// roi_point_pool_3d_top_defines
// Assertion macros used by the checker of the point pool block.
// ----------------------------------------------------------------------------
`ifndef ROI_POINT_POOL_3D_TOP_DEFINES_SVH
`define ROI_POINT_POOL_3D_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RPP3D_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpp3d check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define RPP3D_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpp3d check failed");

`endif

/* hdl/rpp3d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp3d_pkg
// Types and constants of the point-in-rotated-box pooling block.
// ----------------------------------------------------------------------------
package rpp3d_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int MAX_SAMPLES = 64;
  localparam int PT_AW       = $clog2(MAX_POINTS);
  localparam int HL_AW       = $clog2(MAX_SAMPLES);

  localparam int COORD_W  = 24;
  localparam int ANG_W    = 16;
  localparam int ANG_FRAC = 14;
  localparam int IDX_W    = 10;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = DIFF_W + ANG_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int CMP_W    = ACC_W + 2;

  localparam int SCNT_W   = 7;
  localparam int PCNT_W   = 11;
  localparam int KEPT_W   = HL_AW + 1;
  localparam int CFG_DW   = 11;
  localparam int CFG_AW   = 1;

  localparam logic [CFG_AW-1:0] CFG_SAMPLE_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_POINT_COUNT  = 1'd1;

  localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RST = SCNT_W'(MAX_SAMPLES);
  localparam logic [PCNT_W-1:0] POINT_COUNT_RST  = PCNT_W'(MAX_POINTS);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] size_x;
    logic signed [COORD_W-1:0] size_y;
    logic signed [COORD_W-1:0] size_z;
    logic signed [ANG_W-1:0]   cos_angle;
    logic signed [ANG_W-1:0]   sin_angle;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          sampled_index;
    logic signed [COORD_W-1:0] sampled_x;
    logic signed [COORD_W-1:0] sampled_y;
    logic signed [COORD_W-1:0] sampled_z;
    logic                      box_empty;
    logic                      last_sample;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [1:0] {
    ALU_LOAD = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_ADD  = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    en;
    alu_op_e op;
    logic    sel_y;
  } alu_ctl_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRD   = 9'b000000010,
    S_DIFF  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_HRD   = 9'b000100000,
    S_PRD   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_EMPTY = 9'b100000000
  } state_e;

endpackage

/* hdl/rpp3d_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp3d_store
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpp3d_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rpp3d_pkg::PT_AW-1:0] waddr_i,
  input  rpp3d_pkg::point_t           wdata_i,
  input  logic [rpp3d_pkg::PT_AW-1:0] raddr_i,
  output rpp3d_pkg::point_t           rdata_o
);

  rpp3d_pkg::point_t mem [rpp3d_pkg::MAX_POINTS];
  rpp3d_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rpp3d_hitlist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp3d_hitlist
// Slots of the in-box points kept for one query; registered read.
// ----------------------------------------------------------------------------
module rpp3d_hitlist (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rpp3d_pkg::HL_AW-1:0] waddr_i,
  input  logic [rpp3d_pkg::IDX_W-1:0] wdata_i,
  input  logic [rpp3d_pkg::HL_AW-1:0] raddr_i,
  output logic [rpp3d_pkg::IDX_W-1:0] rdata_o
);

  logic [rpp3d_pkg::IDX_W-1:0] mem [rpp3d_pkg::MAX_SAMPLES];
  logic [rpp3d_pkg::IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rpp3d_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp3d_alu
// Shared multiply-accumulate unit: one registered 25x16 product per cycle,
// accumulated into the rotated x or y sum on the following cycle.
// ----------------------------------------------------------------------------
module rpp3d_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rpp3d_pkg::alu_ctl_t                 ctl_i,
  input  logic signed [rpp3d_pkg::DIFF_W-1:0] a_i,
  input  logic signed [rpp3d_pkg::ANG_W-1:0]  b_i,
  output logic signed [rpp3d_pkg::ACC_W-1:0]  acc_x_o,
  output logic signed [rpp3d_pkg::ACC_W-1:0]  acc_y_o
);

  rpp3d_pkg::alu_ctl_t                 ctl_q;
  logic signed [rpp3d_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [rpp3d_pkg::ACC_W-1:0]  prod_ext;
  logic signed [rpp3d_pkg::ACC_W-1:0]  acc_sel;
  logic signed [rpp3d_pkg::ACC_W-1:0]  acc_d;
  logic signed [rpp3d_pkg::ACC_W-1:0]  acc_x_q, acc_y_q;

  assign prod_d   = a_i * b_i;
  assign prod_ext = rpp3d_pkg::ACC_W'(prod_q);
  assign acc_sel  = ctl_q.sel_y ? acc_y_q : acc_x_q;

  always_comb begin
    case (ctl_q.op)
      rpp3d_pkg::ALU_LOAD: acc_d = prod_ext;
      rpp3d_pkg::ALU_SUB:  acc_d = acc_sel - prod_ext;
      rpp3d_pkg::ALU_ADD:  acc_d = acc_sel + prod_ext;
      default:             acc_d = acc_sel;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl_q.en && !ctl_q.sel_y) begin
      acc_x_q <= acc_d;
    end
    if (ctl_q.en && ctl_q.sel_y) begin
      acc_y_q <= acc_d;
    end
  end

  assign acc_x_o = acc_x_q;
  assign acc_y_o = acc_y_q;

endmodule

/* hdl/roi_point_pool_3d_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_point_pool_3d_top
// Point-in-rotated-box sampler over a 1024-entry point store.
// ----------------------------------------------------------------------------
// A load transaction (mode 0) writes one point to the store and the input
// stays ready. A query transaction (mode 1) scans store slots from 0 upward
// through store read, difference, multiply and compare states, since one
// shared multiplier forms the four rotation products of each point; the
// scan ends at point_count slots or as soon as sample_count hits are kept.
// Each result then goes through hit-list read, store read and output load,
// plus any output stall, and an empty box gives a single result through the
// empty state. The input stays stalled for the whole query; the last result
// may still be waiting at the output when the next transaction is taken.
// ----------------------------------------------------------------------------
module roi_point_pool_3d_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rpp3d_pkg::in_item_t          in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rpp3d_pkg::out_item_t         out_o,
  input  logic                         cfg_we_i,
  input  logic [rpp3d_pkg::CFG_AW-1:0] cfg_index_i,
  input  logic [rpp3d_pkg::CFG_DW-1:0] cfg_data_i
);

  rpp3d_pkg::state_e   state_q, state_d;
  rpp3d_pkg::in_item_t box_q, box_d;
  rpp3d_pkg::out_item_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [rpp3d_pkg::SCNT_W-1:0] sample_count_q;
  logic [rpp3d_pkg::PCNT_W-1:0] point_count_q;
  logic [rpp3d_pkg::SCNT_W-1:0] scount;
  logic [rpp3d_pkg::PCNT_W-1:0] pcount;

  logic [rpp3d_pkg::PT_AW-1:0]  scan_idx_q, scan_idx_d;
  logic [rpp3d_pkg::KEPT_W-1:0] kept_q, kept_d;
  logic [rpp3d_pkg::HL_AW-1:0]  hl_idx_q, hl_idx_d;
  logic [rpp3d_pkg::HL_AW-1:0]  smp_idx_q, smp_idx_d;
  logic [2:0]                   phase_q, phase_d;

  logic signed [rpp3d_pkg::DIFF_W-1:0] dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;

  rpp3d_pkg::point_t           st_rdata;
  rpp3d_pkg::point_t           st_wdata;
  logic [rpp3d_pkg::PT_AW-1:0] st_raddr;
  logic                        st_we;
  logic [rpp3d_pkg::IDX_W-1:0] hl_rdata;
  logic                        hl_we;

  rpp3d_pkg::alu_ctl_t                 alu_ctl;
  logic signed [rpp3d_pkg::DIFF_W-1:0] alu_a;
  logic signed [rpp3d_pkg::ANG_W-1:0]  alu_b;
  logic signed [rpp3d_pkg::ACC_W-1:0]  acc_x, acc_y;

  logic [rpp3d_pkg::ACC_W-1:0] abs_x, abs_y;
  logic [rpp3d_pkg::CMP_W-1:0] lim_x, lim_y;
  logic                        in_x, in_y, in_z, in_box;
  logic                        in_acc, out_free, last_pt, last_smp;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // register clamps
  always_comb begin
    scount = sample_count_q;
    if (sample_count_q == '0) begin
      scount = rpp3d_pkg::SCNT_W'(1);
    end else if (sample_count_q > rpp3d_pkg::SCNT_W'(rpp3d_pkg::MAX_SAMPLES)) begin
      scount = rpp3d_pkg::SCNT_W'(rpp3d_pkg::MAX_SAMPLES);
    end
    pcount = point_count_q;
    if (point_count_q > rpp3d_pkg::PCNT_W'(rpp3d_pkg::MAX_POINTS)) begin
      pcount = rpp3d_pkg::PCNT_W'(rpp3d_pkg::MAX_POINTS);
    end
  end

  // box test
  assign abs_x = acc_x[rpp3d_pkg::ACC_W-1] ? rpp3d_pkg::ACC_W'(-acc_x)
                                           : rpp3d_pkg::ACC_W'(acc_x);
  assign abs_y = acc_y[rpp3d_pkg::ACC_W-1] ? rpp3d_pkg::ACC_W'(-acc_y)
                                           : rpp3d_pkg::ACC_W'(acc_y);
  assign lim_x = rpp3d_pkg::CMP_W'(box_q.size_x[rpp3d_pkg::COORD_W-2:0])
                 << rpp3d_pkg::ANG_FRAC;
  assign lim_y = rpp3d_pkg::CMP_W'(box_q.size_y[rpp3d_pkg::COORD_W-2:0])
                 << rpp3d_pkg::ANG_FRAC;
  assign in_x  = !box_q.size_x[rpp3d_pkg::COORD_W-1] && ({1'b0, abs_x, 1'b0} < lim_x);
  assign in_y  = !box_q.size_y[rpp3d_pkg::COORD_W-1] && ({1'b0, abs_y, 1'b0} < lim_y);
  assign in_z  = !dz_q[rpp3d_pkg::DIFF_W-1]
                 && (dz_q <= rpp3d_pkg::DIFF_W'(box_q.size_z));
  assign in_box = in_x && in_y && in_z;

  assign last_pt  = {1'b0, scan_idx_q} == (pcount - rpp3d_pkg::PCNT_W'(1));
  assign last_smp = {1'b0, smp_idx_q} == (scount - rpp3d_pkg::SCNT_W'(1));

  // memory ports
  assign st_we    = in_acc && (in_i.mode == rpp3d_pkg::MODE_LOAD);
  assign st_wdata = '{x: in_i.coord_x, y: in_i.coord_y, z: in_i.coord_z};
  assign st_raddr = (state_q == rpp3d_pkg::S_SRD) ? scan_idx_q
                                                  : hl_rdata[rpp3d_pkg::PT_AW-1:0];
  assign hl_we    = (state_q == rpp3d_pkg::S_CMP) && in_box;

  // four rotation products per point through the shared unit
  always_comb begin
    alu_ctl = '{en: 1'b0, op: rpp3d_pkg::ALU_LOAD, sel_y: 1'b0};
    alu_a   = dx_q;
    alu_b   = box_q.cos_angle;
    if (state_q == rpp3d_pkg::S_MUL) begin
      case (phase_q)
        3'd0: begin
          alu_ctl = '{en: 1'b1, op: rpp3d_pkg::ALU_LOAD, sel_y: 1'b0};
        end
        3'd1: begin
          alu_ctl = '{en: 1'b1, op: rpp3d_pkg::ALU_SUB, sel_y: 1'b0};
          alu_a   = dy_q;
          alu_b   = box_q.sin_angle;
        end
        3'd2: begin
          alu_ctl = '{en: 1'b1, op: rpp3d_pkg::ALU_LOAD, sel_y: 1'b1};
          alu_b   = box_q.sin_angle;
        end
        3'd3: begin
          alu_ctl = '{en: 1'b1, op: rpp3d_pkg::ALU_ADD, sel_y: 1'b1};
          alu_a   = dy_q;
        end
        default: begin
          alu_ctl = '{en: 1'b0, op: rpp3d_pkg::ALU_LOAD, sel_y: 1'b0};
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    box_d       = box_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    scan_idx_d  = scan_idx_q;
    kept_d      = kept_q;
    hl_idx_d    = hl_idx_q;
    smp_idx_d   = smp_idx_q;
    phase_d     = phase_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    dz_d        = dz_q;

    case (state_q)
      rpp3d_pkg::S_IDLE: begin
        if (in_acc && (in_i.mode == rpp3d_pkg::MODE_QUERY)) begin
          box_d      = in_i;
          scan_idx_d = '0;
          kept_d     = '0;
          if (in_i.size_z[rpp3d_pkg::COORD_W-1] || (pcount == '0)) begin
            state_d = rpp3d_pkg::S_EMPTY;
          end else begin
            state_d = rpp3d_pkg::S_SRD;
          end
        end
      end
      rpp3d_pkg::S_SRD: begin
        state_d = rpp3d_pkg::S_DIFF;
      end
      rpp3d_pkg::S_DIFF: begin
        dx_d    = rpp3d_pkg::DIFF_W'(st_rdata.x) - rpp3d_pkg::DIFF_W'(box_q.coord_x);
        dy_d    = rpp3d_pkg::DIFF_W'(st_rdata.y) - rpp3d_pkg::DIFF_W'(box_q.coord_y);
        dz_d    = rpp3d_pkg::DIFF_W'(st_rdata.z) - rpp3d_pkg::DIFF_W'(box_q.coord_z);
        phase_d = '0;
        state_d = rpp3d_pkg::S_MUL;
      end
      rpp3d_pkg::S_MUL: begin
        phase_d = phase_q + 3'd1;
        if (phase_q == 3'd4) begin
          state_d = rpp3d_pkg::S_CMP;
        end
      end
      rpp3d_pkg::S_CMP: begin
        kept_d = kept_q + rpp3d_pkg::KEPT_W'(in_box);
        if (last_pt || (kept_d == scount)) begin
          hl_idx_d  = '0;
          smp_idx_d = '0;
          if (kept_d == '0) begin
            state_d = rpp3d_pkg::S_EMPTY;
          end else begin
            state_d = rpp3d_pkg::S_HRD;
          end
        end else begin
          scan_idx_d = scan_idx_q + rpp3d_pkg::PT_AW'(1);
          state_d    = rpp3d_pkg::S_SRD;
        end
      end
      rpp3d_pkg::S_HRD: begin
        state_d = rpp3d_pkg::S_PRD;
      end
      rpp3d_pkg::S_PRD: begin
        state_d = rpp3d_pkg::S_OUT;
      end
      rpp3d_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{sampled_index: hl_rdata,
                    sampled_x:     st_rdata.x,
                    sampled_y:     st_rdata.y,
                    sampled_z:     st_rdata.z,
                    box_empty:     1'b0,
                    last_sample:   last_smp};
          if (last_smp) begin
            state_d = rpp3d_pkg::S_IDLE;
          end else begin
            smp_idx_d = smp_idx_q + rpp3d_pkg::HL_AW'(1);
            if ((rpp3d_pkg::KEPT_W'(hl_idx_q) + rpp3d_pkg::KEPT_W'(1)) == kept_q) begin
              hl_idx_d = '0;
            end else begin
              hl_idx_d = hl_idx_q + rpp3d_pkg::HL_AW'(1);
            end
            state_d = rpp3d_pkg::S_HRD;
          end
        end
      end
      rpp3d_pkg::S_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{sampled_index: '0,
                    sampled_x:     '0,
                    sampled_y:     '0,
                    sampled_z:     '0,
                    box_empty:     1'b1,
                    last_sample:   1'b1};
          state_d = rpp3d_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rpp3d_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rpp3d_pkg::S_IDLE;
      out_valid_q    <= 1'b0;
      scan_idx_q     <= '0;
      kept_q         <= '0;
      hl_idx_q       <= '0;
      smp_idx_q      <= '0;
      phase_q        <= '0;
      sample_count_q <= rpp3d_pkg::SAMPLE_COUNT_RST;
      point_count_q  <= rpp3d_pkg::POINT_COUNT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      scan_idx_q  <= scan_idx_d;
      kept_q      <= kept_d;
      hl_idx_q    <= hl_idx_d;
      smp_idx_q   <= smp_idx_d;
      phase_q     <= phase_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          rpp3d_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[rpp3d_pkg::SCNT_W-1:0];
          rpp3d_pkg::CFG_POINT_COUNT:  point_count_q  <= cfg_data_i[rpp3d_pkg::PCNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
    out_q <= out_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dz_q  <= dz_d;
  end

  rpp3d_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (in_i.point_index[rpp3d_pkg::PT_AW-1:0]),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  rpp3d_hitlist u_hitlist (
    .clk_i   (clk_i),
    .we_i    (hl_we),
    .waddr_i (kept_q[rpp3d_pkg::HL_AW-1:0]),
    .wdata_i (rpp3d_pkg::IDX_W'(scan_idx_q)),
    .raddr_i (hl_idx_q),
    .rdata_o (hl_rdata)
  );

  rpp3d_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (alu_ctl),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .acc_x_o (acc_x),
    .acc_y_o (acc_y)
  );

  assign in_stall_o  = (state_q != rpp3d_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hdl/rpp3d_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp3d_checker
// Port-level checks of the point pool block, bound to its top level.
// ----------------------------------------------------------------------------
`include "roi_point_pool_3d_top_defines.svh"

module rpp3d_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input rpp3d_pkg::in_item_t          in_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input rpp3d_pkg::out_item_t         out_o,
  input logic                         cfg_we_i,
  input logic [rpp3d_pkg::CFG_AW-1:0] cfg_index_i,
  input logic [rpp3d_pkg::CFG_DW-1:0] cfg_data_i
);

  logic in_acc, cfg_seen, empty_zero, query_acc, load_acc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_seen   = cfg_we_i && (cfg_index_i == cfg_index_i) && (cfg_data_i == cfg_data_i);
  assign empty_zero = (out_o.sampled_index == '0) && (out_o.sampled_x == '0)
                      && (out_o.sampled_y == '0) && (out_o.sampled_z == '0);
  assign query_acc  = in_acc && (in_i.mode == rpp3d_pkg::MODE_QUERY);
  assign load_acc   = in_acc && (in_i.mode == rpp3d_pkg::MODE_LOAD);

  // stalled result holds
  `RPP3D_CHK_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o))
  // empty result is zeroed and marked as the last sample
  `RPP3D_CHK_SAME(a_empty_fmt, out_valid_o && out_o.box_empty, out_o.last_sample && empty_zero)
  // a query keeps the input busy
  `RPP3D_CHK_NEXT(a_query_busy, query_acc, in_stall_o)
  // a load without a config write leaves the input unstalled
  `RPP3D_CHK_NEXT(a_load_fast, load_acc && !cfg_seen, !in_stall_o)
  // more results of the same box still to come
  `RPP3D_CHK_SAME(a_mid_busy, out_valid_o && !out_o.last_sample, in_stall_o)

endmodule

bind roi_point_pool_3d_top rpp3d_checker u_checker (.*);
